// ===== hdl/pdv_pkg.sv =====
// Shared widths and pipeline payload types for the perspective divide block.
`timescale 1ns / 1ps
package pdv_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NUM_W   = 62;  // rounded dividend magnitude
  localparam int DIV_W   = 33;  // divisor 2*|w|
  localparam int LANES   = 3;   // screen x, screen y, depth
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 16;

  localparam logic [CFG_A_W-1:0] REG_VP_X = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_VP_Y = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_VP_W = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_VP_H = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_NEAR = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_FAR  = 3'd5;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] nq;   // dividend bits shift out, quotient bits shift in
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic  [LANES-1:0] neg;
    logic  [DIV_W-1:0] dvs;
    logic              wz;
  } stage_t;

endpackage

// ===== hdl/pdv_front.sv =====
// Front end: products, dividend magnitudes and signs feeding the divider row.
`timescale 1ns / 1ps
module pdv_front
  import pdv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [31:0]   x,
  input  logic signed [31:0]   y,
  input  logic signed [31:0]   z,
  input  logic signed [31:0]   w,
  input  logic [13:0]          vw,
  input  logic [13:0]          vh,
  input  logic [15:0]          near,
  input  logic [15:0]          far,
  output logic                 out_v,
  output stage_t               out_s
);

  logic               v1_r;
  logic signed [46:0] px_r, py_r;
  logic signed [48:0] pz_r;
  logic signed [49:0] pw_r;
  logic signed [31:0] w1_r;
  logic               v2_r;
  stage_t             s2_r;

  logic signed [46:0] px_nxt, py_nxt;
  logic signed [48:0] pz_nxt;
  logic signed [49:0] pw_nxt;
  logic signed [16:0] fmn;
  logic signed [17:0] npf;

  logic signed [63:0] numx, numy, numd;
  logic [63:0]        ax, ay, ad;
  logic [DIV_W-1:0]   aw;
  stage_t             s2_nxt;

  always_comb begin
    fmn    = $signed({1'b0, far}) - $signed({1'b0, near});
    npf    = $signed({2'b0, near}) + $signed({2'b0, far});
    px_nxt = $signed({1'b0, vw}) * x;
    py_nxt = $signed({1'b0, vh}) * y;
    pz_nxt = fmn * z;
    pw_nxt = npf * w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
      pw_r <= pw_nxt;
      w1_r <= w;
    end
  end

  always_comb begin
    numx = {{1{px_r[46]}}, px_r, 16'd0};
    numy = -{{1{py_r[46]}}, py_r, 16'd0};
    numd = 64'(pz_r) + 64'(pw_r);
    ax   = numx[63] ? -numx : numx;
    ay   = numy[63] ? -numy : numy;
    ad   = numd[63] ? -numd : numd;
    aw   = w1_r[31] ? -{w1_r[31], w1_r} : {1'b0, w1_r};
    s2_nxt.wz  = (w1_r == 32'sd0);
    s2_nxt.dvs = {aw[DIV_W-2:0], 1'b0};
    // Add half the divisor for round half away from zero.
    s2_nxt.lane[0].nq  = NUM_W'(ax + 64'(aw));
    s2_nxt.lane[1].nq  = NUM_W'(ay + 64'(aw));
    s2_nxt.lane[2].nq  = NUM_W'(ad + 64'(aw));
    s2_nxt.lane[0].rem = '0;
    s2_nxt.lane[1].rem = '0;
    s2_nxt.lane[2].rem = '0;
    s2_nxt.neg[0] = numx[63] ^ w1_r[31];
    s2_nxt.neg[1] = numy[63] ^ w1_r[31];
    s2_nxt.neg[2] = numd[63] ^ w1_r[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_v = v2_r;
  assign out_s = s2_r;

endmodule

// ===== hdl/pdv_cell.sv =====
// Divider cell: one restoring quotient bit for each lane, then hand off.
`timescale 1ns / 1ps
module pdv_cell
  import pdv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_v,
  input  stage_t in_s,
  output logic   out_v,
  output stage_t out_s
);

  logic   v_r;
  stage_t s_r;
  stage_t s_nxt;
  logic [DIV_W:0] t [LANES];
  logic [LANES-1:0] qb;

  always_comb begin
    s_nxt = in_s;
    for (int i = 0; i < LANES; i++) begin
      t[i]  = {in_s.lane[i].rem, in_s.lane[i].nq[NUM_W-1]};
      qb[i] = (t[i] >= {1'b0, in_s.dvs});
      s_nxt.lane[i].rem = qb[i] ? DIV_W'(t[i] - {1'b0, in_s.dvs}) : DIV_W'(t[i]);
      s_nxt.lane[i].nq  = {in_s.lane[i].nq[NUM_W-2:0], qb[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign out_v = v_r;
  assign out_s = s_r;

endmodule

// ===== hdl/pdv_back.sv =====
// Back end: sign, viewport offset, saturation and the output register.
`timescale 1ns / 1ps
module pdv_back
  import pdv_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  stage_t      in_s,
  input  logic [12:0] vx,
  input  logic [12:0] vy,
  input  logic [13:0] vw,
  input  logic [13:0] vh,
  output logic        out_v,
  output logic [31:0] sx,
  output logic [31:0] sy,
  output logic [15:0] dep,
  output logic        wz
);

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  logic        v_r;
  logic [31:0] sx_r, sy_r;
  logic [15:0] dep_r;
  logic        wz_r;

  logic signed [63:0] q [LANES];
  logic signed [63:0] fx, fy, cx, cy;
  logic [31:0]        sx_nxt, sy_nxt;
  logic [15:0]        dep_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      q[i] = in_s.neg[i] ? -$signed({2'b0, in_s.lane[i].nq})
                         :  $signed({2'b0, in_s.lane[i].nq});
    end
    fx = q[0] + $signed({35'd0, vx, 16'd0}) + $signed({35'd0, vw, 15'd0});
    fy = q[1] + $signed({35'd0, vy, 16'd0}) + $signed({35'd0, vh, 15'd0});
    priority if (fx > SAT_HI) cx = SAT_HI;
    else if (fx < SAT_LO)     cx = SAT_LO;
    else                      cx = fx;
    priority if (fy > SAT_HI) cy = SAT_HI;
    else if (fy < SAT_LO)     cy = SAT_LO;
    else                      cy = fy;
    priority if (q[2] < 64'sd0)     dep_nxt = 16'd0;
    else if (q[2] > 64'sd65535)     dep_nxt = 16'hFFFF;
    else                            dep_nxt = q[2][15:0];
    sx_nxt = cx[31:0];
    sy_nxt = cy[31:0];
    if (in_s.wz) begin
      sx_nxt  = '0;
      sy_nxt  = '0;
      dep_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      dep_r <= dep_nxt;
      wz_r  <= in_s.wz;
    end
  end

  assign out_v = v_r;
  assign sx    = sx_r;
  assign sy    = sy_r;
  assign dep   = dep_r;
  assign wz    = wz_r;

endmodule

// ===== hdl/perspective_divide_viewport.sv =====
// Top level: config registers, front end, divider row and output stage.
`timescale 1ns / 1ps
// Perspective divide and viewport transform. Accepts one clip-space vertex per
// cycle while in_stall is low and returns one window-space vertex per vertex, in
// order, through two front stages (products, then rounded dividend magnitudes),
// a row of 62 divider cells that each resolve one quotient bit for x, y and
// depth together, and one stage for offset, saturation and the output register.
// The whole pipe advances unless the output holds a beat that is stalled, so
// in_stall follows out_stall only while the output is full.
// Configuration registers may only be written while no vertex is in flight.
module perspective_divide_viewport
  import pdv_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_A_W-1:0]   cfg_addr,
  input  logic [CFG_D_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_clip_x,
  input  logic signed [31:0]   in_clip_y,
  input  logic signed [31:0]   in_clip_z,
  input  logic signed [31:0]   in_clip_w,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_screen_x,
  output logic signed [31:0]   out_screen_y,
  output logic [15:0]          out_depth,
  output logic                 out_w_zero
);

  logic [12:0] vp_x_r, vp_y_r;
  logic [13:0] vp_w_r, vp_h_r;
  logic [15:0] near_r, far_r;
  logic        en;

  logic   cv [NUM_W+1];
  stage_t cs [NUM_W+1];
  logic [31:0] sx, sy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_x_r <= 13'd0;
      vp_y_r <= 13'd0;
      vp_w_r <= 14'd640;
      vp_h_r <= 14'd480;
      near_r <= 16'd0;
      far_r  <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_VP_X: vp_x_r <= cfg_wdata[12:0];
        REG_VP_Y: vp_y_r <= cfg_wdata[12:0];
        REG_VP_W: vp_w_r <= cfg_wdata[13:0];
        REG_VP_H: vp_h_r <= cfg_wdata[13:0];
        REG_NEAR: near_r <= cfg_wdata;
        REG_FAR:  far_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the whole pipe only when the output beat is stalled.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  pdv_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .x     (in_clip_x),
    .y     (in_clip_y),
    .z     (in_clip_z),
    .w     (in_clip_w),
    .vw    (vp_w_r),
    .vh    (vp_h_r),
    .near  (near_r),
    .far   (far_r),
    .out_v (cv[0]),
    .out_s (cs[0])
  );

  for (genvar g = 0; g < NUM_W; g++) begin : g_cell
    pdv_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (cv[g]),
      .in_s  (cs[g]),
      .out_v (cv[g+1]),
      .out_s (cs[g+1])
    );
  end

  pdv_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (cv[NUM_W]),
    .in_s  (cs[NUM_W]),
    .vx    (vp_x_r),
    .vy    (vp_y_r),
    .vw    (vp_w_r),
    .vh    (vp_h_r),
    .out_v (out_valid),
    .sx    (sx),
    .sy    (sy),
    .dep   (out_depth),
    .wz    (out_w_zero)
  );

  assign out_screen_x = $signed(sx);
  assign out_screen_y = $signed(sy);

  a_wz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |-> out_screen_x == 32'sd0 && out_screen_y == 32'sd0
                               && out_depth == 16'd0)
    else $error("w_zero beat carries nonzero coordinates");

  a_stall_src : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output can move");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_screen_x) && $stable(out_depth))
    else $error("stalled output beat changed");

endmodule

// ===== tb/pdv_checker.sv =====
// Checker for the perspective divide block: predicts each vertex and compares.
`timescale 1ns / 1ps
module pdv_checker
  import pdv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_D_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic signed [31:0]  in_clip_x,
  input  logic signed [31:0]  in_clip_y,
  input  logic signed [31:0]  in_clip_z,
  input  logic signed [31:0]  in_clip_w,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [31:0]  out_screen_x,
  input  logic signed [31:0]  out_screen_y,
  input  logic [15:0]         out_depth,
  input  logic                out_w_zero,
  output int                  errors,
  output int                  pending,
  output int                  beats_checked,
  output int                  w_zero_seen
);

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [15:0]        depth;
    logic               wz;
  } window_vertex_t;

  logic [12:0] vp_x, vp_y;
  logic [13:0] vp_w, vp_h;
  logic [15:0] z_near, z_far;

  window_vertex_t expected_vertices[$];

  // Quotient rounded half away from zero.
  function automatic longint div_half_away(longint num, longint den);
    longint an, ad, q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an + ad / 2) / ad;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< 31) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic window_vertex_t project_vertex(logic signed [31:0] cx, cy, cz, cw);
    window_vertex_t r;
    longint x, y, z, w, vw, vh, n, f, sx, sy, d;
    x = cx; y = cy; z = cz; w = cw;
    vw = vp_w; vh = vp_h; n = z_near; f = z_far;
    if (w == 0) begin
      r.sx = '0; r.sy = '0; r.depth = '0; r.wz = 1'b1;
      return r;
    end
    sx = div_half_away(vw * x * 65536, 2 * w) + longint'(vp_x) * 65536 + vw * 32768;
    sy = div_half_away(-(vh * y * 65536), 2 * w) + longint'(vp_y) * 65536 + vh * 32768;
    d = div_half_away((f - n) * z + (n + f) * w, 2 * w);
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    r.sx = 32'(clamp_coord(sx));
    r.sy = 32'(clamp_coord(sy));
    r.depth = d[15:0];
    r.wz = 1'b0;
    return r;
  endfunction

  task automatic report(string field, longint exp_v, longint got_v);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field, exp_v, got_v);
    errors++;
  endtask

  initial begin
    errors = 0;
    beats_checked = 0;
    w_zero_seen = 0;
  end

  assign pending = expected_vertices.size();

  always @(posedge clk) begin
    window_vertex_t e;
    if (!rst_n) begin
      vp_x <= 13'd0; vp_y <= 13'd0; vp_w <= 14'd640; vp_h <= 14'd480;
      z_near <= 16'd0; z_far <= 16'd65535;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_VP_X: vp_x   <= cfg_wdata[12:0];
          REG_VP_Y: vp_y   <= cfg_wdata[12:0];
          REG_VP_W: vp_w   <= cfg_wdata[13:0];
          REG_VP_H: vp_h   <= cfg_wdata[13:0];
          REG_NEAR: z_near <= cfg_wdata;
          REG_FAR:  z_far  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_vertices.insert(expected_vertices.size(),
                                 project_vertex(in_clip_x, in_clip_y, in_clip_z, in_clip_w));
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (out_w_zero) w_zero_seen++;
        if (expected_vertices.size() == 0) begin
          $display("unexpected beat at %0t", $realtime);
          errors++;
        end else begin
          e = expected_vertices.pop_front();
          if (out_screen_x !== e.sx)
            report("screen_x", longint'(e.sx), longint'(out_screen_x));
          if (out_screen_y !== e.sy)
            report("screen_y", longint'(e.sy), longint'(out_screen_y));
          if (out_depth !== e.depth)
            report("depth", longint'(e.depth), longint'(out_depth));
          if (out_w_zero !== e.wz)
            report("w_zero", longint'(e.wz), longint'(out_w_zero));
        end
      end
    end
  end

endmodule

// ===== tb/tb_perspective_divide_viewport.sv =====
// Testbench top: clock, reset, vertex and register stimulus, and the verdict.
`timescale 1ns / 1ps
module tb_perspective_divide_viewport;
  import pdv_pkg::*;

  localparam logic [CFG_A_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_A_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PER_PHASE = 240;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_D_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_clip_x = '0, in_clip_y = '0, in_clip_z = '0, in_clip_w = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] out_screen_x, out_screen_y;
  logic [15:0] out_depth;
  logic out_w_zero;

  int errors, pending, beats_checked, w_zero_seen;
  int vertices_sent = 0;
  int settings_run = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  perspective_divide_viewport dut (.*);

  pdv_checker u_checker (.*);

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stall per beat, with one long hold-off to back the pipe up.
  initial begin
    int k;
    int beats;
    beats = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      k = rx_burst ? 0 : $urandom_range(0, 18);
      if (beats == 300) k = 400;
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

  task automatic cfg_write(logic [CFG_A_W-1:0] addr, logic [CFG_D_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_viewport(int vx, int vy, int vw, int vh, int zn, int zf);
    cfg_write(REG_VP_X, CFG_D_W'(vx));
    cfg_write(REG_VP_Y, CFG_D_W'(vy));
    cfg_write(REG_VP_W, CFG_D_W'(vw));
    cfg_write(REG_VP_H, CFG_D_W'(vh));
    cfg_write(REG_NEAR, CFG_D_W'(zn));
    cfg_write(REG_FAR, CFG_D_W'(zf));
    settings_run++;
  endtask

  // Called on a falling edge; returns on the falling edge after the beat is taken.
  task automatic send_vertex(logic [31:0] x, y, z, w);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_clip_x <= x;
    in_clip_y <= y;
    in_clip_z <= z;
    in_clip_w <= w;
    do @(posedge clk); while (in_stall);
    vertices_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_batch(int count);
    logic [31:0] x, y, z, w;
    int sel;
    repeat (count) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        // inside the view volume or close to it
        w = $urandom_range(1, 1 << $urandom_range(8, 24));
        if ($urandom_range(0, 3) == 0) w = -w;
        x = $signed($urandom_range(0, 2 * w[30:0])) - $signed(w[30:0]);
        y = $signed($urandom_range(0, 2 * w[30:0])) - $signed(w[30:0]);
        z = $signed($urandom_range(0, 2 * w[30:0])) - $signed(w[30:0]);
        if ($urandom_range(0, 7) == 0) z = z * 2;
      end else begin
        x = $urandom; y = $urandom; z = $urandom; w = $urandom;
        if (sel == 9) w = $urandom_range(0, 2) - 1;
      end
      send_vertex(x, y, z, w);
    end
  endtask

  // Drop valid so the last vertex is not taken again, then let the pipe empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, directed corners
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_vertex(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 32'h0001_0000);
    send_vertex(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0002);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002);
    send_vertex(32'h0002_0000, 32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFF_0000);
    send_vertex(32'h0003_0000, 32'h0005_0000, 32'h0007_0000, 32'h0003_0000);
    send_random_batch(RANDOM_PER_PHASE);
    drain();

    // smallest viewport, zero depth range
    apply_viewport(0, 0, 1, 1, 0, 0);
    send_random_batch(RANDOM_PER_PHASE);
    drain();

    // largest legal viewport, full far
    apply_viewport(8191, 8191, 8192, 8192, 65535, 65535);
    send_random_batch(RANDOM_PER_PHASE);
    drain();

    // oversized extent, reversed depth, writes that spill over register width
    apply_viewport(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 65535, 0);
    cfg_write(REG_SPARE_LO, 16'h1234);
    cfg_write(REG_SPARE_HI, 16'hFFFF);
    send_random_batch(RANDOM_PER_PHASE);
    drain();

    // collapsed viewport
    apply_viewport(100, 200, 0, 0, 1000, 60000);
    send_random_batch(RANDOM_PER_PHASE);
    drain();

    repeat (3) begin
      apply_viewport($urandom_range(0, 8191), $urandom_range(0, 8191),
                     $urandom_range(1, 8192), $urandom_range(1, 8192),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
      send_random_batch(RANDOM_PER_PHASE);
      drain();
    end

    in_valid <= 1'b0;
    @(negedge clk);

    $display("covered %0d vertices (%0d with w zero) over %0d register settings",
             vertices_sent, w_zero_seen, settings_run + 1);
    $display("checked %0d result beats, %0d still outstanding", beats_checked, pending);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
